// ===== hw/rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types and constants of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_START,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic done;
    } t_rnd_ctl;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== hw/rtl/sha_if.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for input bytes and digest words.
// ----------------------------------------------------------------------------
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_position;
    logic        last_word;
    modport source (output valid, digest_word, word_position, last_word, input ready);
    modport sink   (input valid, digest_word, word_position, last_word, output ready);
endinterface

// ===== hw/rtl/sha_round.sv =====
// ----------------------------------------------------------------------------
// SHA-256 round engine
// One compression round per cycle with a rolling 16-word schedule.
// ----------------------------------------------------------------------------
module sha_round (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sha_pkg::t_rnd_ctl i_ctl,
    input  logic [31:0]      i_chain [8],
    input  logic [31:0]      i_block [16],
    output logic             o_done,
    output logic [31:0]      o_work [8]
);
    import sha_pkg::*;

    logic        r_busy;
    logic [5:0]  r_round;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] w_new, w_cur, s1, ch, t1, s0, mj;

    // Window holds W[t..t+15] at round t; next word is computed from it.
    always_comb begin
        w_cur = r_w[0];
        w_new = (rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10)) + r_w[9]
              + (rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3)) + r_w[0];
        s1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + s1 + ch + K[r_round] + w_cur;
        s0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= '0;
        end else if (i_ctl.start) begin
            r_busy  <= 1'b1;
            r_round <= '0;
        end else if (r_busy) begin
            r_round <= r_round + 6'd1;
            if (r_round == 6'd63) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_w <= i_block;
            r_v <= i_chain;
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + s0 + mj;
        end
    end

    assign o_done = r_busy && (r_round == 6'd63);
    assign o_work = r_v;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_busy) else $error("round start while busy");
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !r_busy) else $error("engine still busy after last round");
    a_round_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_round == 6'd0) else $error("round count nonzero when idle");
endmodule

// ===== hw/rtl/sha256_stream_hasher.sv =====
// A byte that does not fill a block is taken in ST_IDLE; a full block adds a
// start state, the round pass of ST_ROUND and a fold into the chaining value in
// ST_ADD. End of message: a pad state, then one or two final compressions,
// then 8 digest transfers, one per cycle when the output is ready.
// Throughput is set by the single shared round engine: 64 rounds per 64 bytes.
// Reset (synchronous, active low) restores the initial hash and a zero count.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Absorbs a byte stream, pads at message end and emits the 256-bit digest.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
    input  logic i_clk,
    input  logic i_rst_n,
    sha_in_if.sink    in_s,
    sha_out_if.source out_s
);
    import sha_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_chain [8];
    logic [31:0] r_block [16];
    logic [60:0] r_count;
    // Set from padding until the digest is out; r_more marks a second (length) block.
    logic        r_final;
    logic        r_more;
    logic [2:0]  r_opos;
    // A pending end of message after a filling byte goes to padding next.
    logic        r_eom_wait;
    logic        done;
    logic [31:0] work [8];
    t_rnd_ctl    ctl;
    logic        acc;
    logic [5:0]  pos;
    logic        fills;
    logic [63:0] bits;

    assign acc   = in_s.valid && in_s.ready;
    assign pos   = r_count[5:0];
    assign fills = in_s.byte_present && (pos == 6'd63);
    assign bits  = {r_count, 3'b000};

    sha_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_chain (r_chain),
        .i_block (r_block),
        .o_done  (done),
        .o_work  (work)
    );

    // Next state. The engine is always started from ST_START, in the cycle after
    // the block buffer and the chaining value have settled.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && fills) n_state = ST_START;
                else if (acc && in_s.end_of_message) n_state = ST_PAD;
            end
            ST_PAD:   n_state = ST_START;
            ST_START: n_state = ST_ROUND;
            ST_ROUND: if (done) n_state = ST_ADD;
            ST_ADD: begin
                if (r_more) n_state = ST_START;
                else if (r_final) n_state = ST_OUT;
                else if (r_eom_wait) n_state = ST_PAD;
                else n_state = ST_IDLE;
            end
            ST_OUT: if (out_s.ready && r_opos == 3'd7) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        in_s.ready = 1'b0;
        out_s.valid = 1'b0;
        ctl.start = 1'b0;
        ctl.done = done;
        unique case (r_state)
            ST_IDLE:  in_s.ready = 1'b1;
            ST_START: ctl.start = 1'b1;
            ST_OUT:   out_s.valid = 1'b1;
            default: ;
        endcase
    end

    assign out_s.digest_word   = r_chain[r_opos];
    assign out_s.word_position = r_opos;
    assign out_s.last_word     = (r_opos == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_chain <= IV;
            r_count <= '0;
            r_final <= 1'b0;
            r_more  <= 1'b0;
            r_opos  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        if (in_s.byte_present) r_count <= r_count + 61'd1;
                        // A byte that fills the block with end of message still
                        // needs the padding pass after this compression.
                        if (fills && in_s.end_of_message) begin
                            r_more  <= 1'b0;
                            r_final <= 1'b0;
                        end
                    end
                end
                ST_PAD: begin
                    r_final <= 1'b1;
                    r_more  <= (pos > 6'd55);
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) r_chain[i] <= r_chain[i] + work[i];
                    r_more <= 1'b0;
                end
                ST_OUT: begin
                    if (out_s.ready) begin
                        r_opos <= r_opos + 3'd1;
                        if (r_opos == 3'd7) begin
                            r_chain <= IV;
                            r_count <= '0;
                            r_final <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eom_wait <= 1'b0;
        end else if (r_state == ST_IDLE && acc && fills) begin
            r_eom_wait <= in_s.end_of_message;
        end else if (r_state == ST_PAD) begin
            r_eom_wait <= 1'b0;
        end
    end

    // Block buffer: byte writes, padding fill and second-block length fill.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && acc && in_s.byte_present) begin
            r_block[pos[5:2]][8*(3-pos[1:0]) +: 8] <= in_s.data_byte;
        end else if (r_state == ST_PAD) begin
            for (int b = 0; b < 64; b++) begin
                if (b[5:0] == pos) r_block[b/4][8*(3-b%4) +: 8] <= PAD_BYTE;
                else if (b[5:0] > pos) begin
                    if (b >= 56 && pos <= 6'd55)
                        r_block[b/4][8*(3-b%4) +: 8] <= bits[8*(63-b) +: 8];
                    else
                        r_block[b/4][8*(3-b%4) +: 8] <= 8'h00;
                end
            end
        end else if (r_state == ST_ADD && r_more) begin
            for (int j = 0; j < 14; j++) r_block[j] <= '0;
            r_block[14] <= bits[63:32];
            r_block[15] <= bits[31:0];
        end
    end

    a_out_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_s.valid |-> r_final) else $error("digest shown before final block");
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_s.ready |-> !out_s.valid) else $error("input ready while emitting");
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_s.valid && out_s.ready && out_s.last_word) |=> r_state == ST_IDLE)
        else $error("no return to idle after digest");
endmodule

// ===== bench/sha256_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both stream channels, computes each message digest on its own and
// compares every digest word transfer against the oldest expected word.
// ----------------------------------------------------------------------------
module sha256_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sha_in_if.sink    in_m,
    sha_out_if.sink   out_m,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_digests
);
    import sha_pkg::*;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  pos;
        logic        last;
    } t_digest_word;

    t_digest_word digest_fifo[$];
    logic [31:0] hash_state [8];
    logic [31:0] msg_block [16];
    logic [60:0] byte_total;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] v [8];
        logic [31:0] w [64];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++) w[i] = msg_block[i];
        for (int i = 16; i < 64; i++)
            w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        v = hash_state;
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic put_byte(input int pos, input logic [7:0] b);
        msg_block[pos / 4][(3 - pos % 4) * 8 +: 8] = b;
    endtask

    task automatic absorb(input logic [7:0] b, input logic present, input logic eom);
        int pos;
        logic [63:0] bit_len;
        if (present) begin
            pos = byte_total[5:0];
            put_byte(pos, b);
            byte_total++;
            if (pos == 63) compress_block();
        end
        if (!eom) return;
        pos = byte_total[5:0];
        put_byte(pos, PAD_BYTE);
        pos++;
        if (pos > 56) begin
            while (pos < 64) begin
                put_byte(pos, 8'h00);
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56) begin
            put_byte(pos, 8'h00);
            pos++;
        end
        bit_len = {byte_total, 3'b000};
        for (int i = 0; i < 8; i++) put_byte(56 + i, bit_len[63 - 8*i -: 8]);
        compress_block();
        for (int i = 0; i < 8; i++)
            digest_fifo.push_back('{hash_state[i], 3'(i), i == 7});
        hash_state = IV;
        byte_total = '0;
    endtask

    assign o_pending = digest_fifo.size();

    always @(posedge i_clk) begin
        t_digest_word exp_w;
        if (!i_rst_n) begin
            hash_state = IV;
            byte_total = '0;
            digest_fifo.delete();
            o_fail_count <= 0;
            o_digests <= 0;
        end else begin
            if (in_m.valid && in_m.ready)
                absorb(in_m.data_byte, in_m.byte_present, in_m.end_of_message);
            if (out_m.valid && out_m.ready) begin
                if (digest_fifo.size() == 0) begin
                    $error("digest word transfer with nothing expected: %h",
                           out_m.digest_word);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = digest_fifo.pop_front();
                    if (out_m.digest_word !== exp_w.word ||
                        out_m.word_position !== exp_w.pos ||
                        out_m.last_word !== exp_w.last)
                        o_fail_count <= o_fail_count + 1;
                    if (out_m.digest_word !== exp_w.word)
                        $error("digest_word expected %h actual %h",
                               exp_w.word, out_m.digest_word);
                    if (out_m.word_position !== exp_w.pos)
                        $error("word_position expected %0d actual %0d",
                               exp_w.pos, out_m.word_position);
                    if (out_m.last_word !== exp_w.last)
                        $error("last_word expected %b actual %b",
                               exp_w.last, out_m.last_word);
                    if (exp_w.last) o_digests <= o_digests + 1;
                end
            end
        end
    end
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds directed and random messages through the hasher with random gaps on
// both channels; a checker beside the block predicts and compares digests.
// ----------------------------------------------------------------------------
module testbench;
    // Generous bound: no message is longer than 64 bytes, so the whole run should
    // end well within it even with long gaps on both sides.
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    int   fail_count;
    int   pending_words;
    int   digest_count;
    int   item_count;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_stream_hasher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_s    (in_ch.sink),
        .out_s   (out_ch.source)
    );

    sha256_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_m         (in_ch.sink),
        .out_m        (out_ch.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending_words),
        .o_digests    (digest_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog over the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Output back-pressure. Some stretches run with ready held high.
    logic steady_ready;
    initial begin
        out_ch.ready = 1'b0;
        steady_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 199) == 0) steady_ready = ~steady_ready;
            out_ch.ready <= steady_ready ? 1'b1 : ($urandom_range(0, 99) < 40 ? 1'b0 : 1'b1);
            if (!steady_ready && $urandom_range(0, 99) < 3)
                repeat ($urandom_range(10, 40)) @(negedge i_clk);
        end
    end

    // Drive one item and hold it until the transfer is taken.
    task automatic send_item(input logic [7:0] b, input logic present,
                             input logic eom, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= b;
        in_ch.byte_present   <= present;
        in_ch.end_of_message <= eom;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (present || eom) item_count++;
    endtask

    // A message of len bytes with either fixed or random content; stray empty
    // items and an end marker without a byte are mixed in.
    task automatic send_message(input int len, input int fill, input bit no_gap);
        logic [7:0] b;
        bit         bare_end;
        bare_end = $urandom_range(0, 3) == 0 || len == 0;
        for (int i = 0; i < len; i++) begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (!no_gap && $urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0, 0);
            send_item(b, 1'b1, (i == len - 1) && !bare_end, no_gap);
        end
        if (bare_end) send_item(8'($urandom), 1'b0, 1'b1, no_gap);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_words != 0) @(negedge i_clk);
    endtask

    initial begin
        int len;
        cycle_count = 0;
        item_count = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.byte_present = 1'b0;
        in_ch.end_of_message = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty message, single extreme bytes, and lengths around
        // the padding boundary where one or two final compressions are needed.
        send_message(0, 0, 1);
        send_message(1, 8'h00, 1);
        send_message(1, 8'hff, 0);
        send_item(8'h5a, 1'b0, 1'b0, 0);
        send_message(3, 8'h61, 0);
        drain();
        send_message(56, -1, 1);
        send_message(64, 8'hff, 0);

        // Pause the sender until the hasher has emitted everything.
        drain();

        // Random short messages up to the item budget.
        for (int m = 0; m < 30; m++) begin
            if (item_count >= 150) break;
            len = $urandom_range(0, 8);
            send_message(len, -1, $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) drain();
        end

        drain();
        repeat (200) @(negedge i_clk);
        $display("Covered %0d input items and %0d digests, including empty,", item_count,
                 digest_count);
        $display("padding-boundary and multi-block messages under random stalls.");
        if (fail_count == 0 && pending_words == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== sha256_stream_hasher.f =====
hw/rtl/sha_pkg.sv
hw/rtl/sha_if.sv
hw/rtl/sha_round.sv
hw/rtl/sha256_stream_hasher.sv
bench/sha256_checker.sv
bench/testbench.sv
